// File: rtl/fsgd_pkg.sv
package fsgd_pkg;

    // Header limits and protocol number
    localparam int unsigned MIN_HEADER_BYTES = 20;
    localparam logic [3:0]  MIN_HEADER_WORDS = 4'(MIN_HEADER_BYTES / 4);
    localparam logic [7:0]  TCP_PROTOCOL     = 8'h06;

    // Stream widths
    localparam int unsigned S_DATA_W = 144;
    localparam int unsigned M_DATA_W = 72;
    localparam int unsigned KEY_W    = 96;

    // Result kinds
    typedef enum logic [2:0] {
        KIND_LOST    = 3'd0,
        KIND_OK      = 3'd1,
        KIND_BAD_IP  = 3'd2,
        KIND_BAD_TCP = 3'd3,
        KIND_NOT_TCP = 3'd4,
        KIND_FULL    = 3'd5
    } kind_t;

    // Input beat, last field listed here in the lowest bits
    typedef struct packed {
        logic [31:0] packet_seq;
        logic [15:0] dest_port;
        logic [15:0] source_port;
        logic [31:0] dest_addr;
        logic [31:0] source_addr;
        logic [3:0]  tcp_offset_words;
        logic [7:0]  ip_protocol;
        logic [3:0]  ip_header_words;
    } in_beat_t;

    // Output beat payload, last field listed here in the lowest bits
    typedef struct packed {
        logic [6:0]  pad;
        logic        truncated;
        logic [31:0] sender_addr;
        logic [31:0] lost_seq;
    } out_beat_t;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic scan;
        logic resolve;
        logic commit;
        logic emit_lost;
        logic emit_status;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic tcp_ok;
        logic hit;
        logic miss;
        logic table_full;
        logic cnt_zero;
        logic out_free;
    } status_t;

endpackage

// File: rtl/fsgd_ctrl.sv
module fsgd_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  fsgd_pkg::status_t st,
    output fsgd_pkg::cmd_t    cmd
);
    import fsgd_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_SCAN   = 6'b000010,
        ST_COMMIT = 6'b000100,
        ST_LOST   = 6'b001000,
        ST_STATUS = 6'b010000,
        ST_SPARE  = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Sequence one packet at a time through lookup, update and reporting
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (!st.tcp_ok)
                begin
                    state_next = ST_STATUS;
                end
                else if (st.hit)
                begin
                    cmd.resolve = 1'b1;
                    state_next  = ST_COMMIT;
                end
                else if (st.miss)
                begin
                    cmd.resolve = 1'b1;
                    state_next  = st.table_full ? ST_STATUS : ST_COMMIT;
                end
            end
            ST_COMMIT:
            begin
                cmd.commit = 1'b1;
                state_next = ST_LOST;
            end
            ST_LOST:
            begin
                if (st.cnt_zero)
                begin
                    state_next = ST_STATUS;
                end
                else if (st.out_free)
                begin
                    cmd.emit_lost = 1'b1;
                end
            end
            ST_STATUS:
            begin
                if (st.out_free)
                begin
                    cmd.emit_status = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// File: rtl/fsgd_datapath.sv
module fsgd_datapath #(
    parameter int unsigned FLOW_ENTRIES = 64,
    parameter int unsigned MAX_REPORTED = 63
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [fsgd_pkg::S_DATA_W-1:0]   s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [fsgd_pkg::M_DATA_W-1:0]   m_tdata,
    output logic [2:0]                      m_tuser,
    output logic                            m_tlast,
    input  fsgd_pkg::cmd_t                  cmd,
    output fsgd_pkg::status_t               st
);
    import fsgd_pkg::*;

    localparam int unsigned AW    = $clog2(FLOW_ENTRIES);
    localparam int unsigned FW    = $clog2(FLOW_ENTRIES + 1);
    localparam int unsigned CNT_W = $clog2(MAX_REPORTED + 1);

    in_beat_t in_beat;

    // Packet held for the whole transaction
    logic [KEY_W-1:0] key_reg;
    logic [31:0]      src_reg;
    logic [31:0]      seq_reg;
    kind_t            kind_reg;

    // Flow table
    logic [KEY_W-1:0] flow_key_mem [FLOW_ENTRIES];
    logic [31:0]      flow_seq_mem [FLOW_ENTRIES];
    logic [KEY_W-1:0] key_rd_reg;
    logic [31:0]      seq_rd_reg;
    logic [AW-1:0]    rd_idx_reg;

    // Scan and fill control
    logic [FW-1:0]    fill_reg;
    logic [FW-1:0]    fill_next;
    logic [FW-1:0]    scan_cnt_reg;
    logic [FW-1:0]    scan_cnt_next;
    logic             rv_reg;
    logic             rv_next;
    logic             issue;

    // Resolved flow and gap
    logic [AW-1:0]    widx_reg;
    logic             new_reg;
    logic [31:0]      exp_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             trunc_reg;
    logic             seq_ahead;
    logic [31:0]      gap;
    logic             gap_over;

    // Output stage
    logic             m_tvalid_reg;
    logic             m_tvalid_next;
    out_beat_t        out_reg;
    kind_t            out_kind_reg;
    logic             out_last_reg;

    assign in_beat = in_beat_t'(s_tdata);

    // Status toward the controller
    assign st.tcp_ok     = (kind_reg == KIND_OK);
    assign st.hit        = rv_reg && (key_rd_reg == key_reg);
    assign st.miss       = !rv_reg && (scan_cnt_reg == fill_reg);
    assign st.table_full = (fill_reg == FW'(FLOW_ENTRIES));
    assign st.cnt_zero   = (cnt_reg == '0);
    assign st.out_free   = !m_tvalid_reg || m_tready;

    // Capture the packet and classify its headers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            key_reg <= {in_beat.source_addr, in_beat.dest_addr,
                        in_beat.source_port, in_beat.dest_port};
            src_reg <= in_beat.source_addr;
            seq_reg <= in_beat.packet_seq;
            if (in_beat.ip_header_words < MIN_HEADER_WORDS)
            begin
                kind_reg <= KIND_BAD_IP;
            end
            else if (in_beat.ip_protocol != TCP_PROTOCOL)
            begin
                kind_reg <= KIND_NOT_TCP;
            end
            else if (in_beat.tcp_offset_words < MIN_HEADER_WORDS)
            begin
                kind_reg <= KIND_BAD_TCP;
            end
            else
            begin
                kind_reg <= KIND_OK;
            end
        end
        else if (cmd.resolve && !st.hit && st.table_full)
        begin
            kind_reg <= KIND_FULL;
        end
    end

    // Walk the filled entries, one read per cycle
    assign issue         = cmd.scan && (scan_cnt_reg != fill_reg);
    assign scan_cnt_next = cmd.load ? '0 : (issue ? scan_cnt_reg + 1'b1 : scan_cnt_reg);
    assign rv_next       = cmd.load ? 1'b0 : issue;
    assign fill_next     = (cmd.commit && new_reg) ? fill_reg + 1'b1 : fill_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg     <= '0;
            scan_cnt_reg <= '0;
            rv_reg       <= 1'b0;
        end
        else
        begin
            fill_reg     <= fill_next;
            scan_cnt_reg <= scan_cnt_next;
            rv_reg       <= rv_next;
        end
    end

    // Flow table port: one read or one write per cycle
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            flow_key_mem[widx_reg] <= key_reg;
            flow_seq_mem[widx_reg] <= seq_reg;
        end
        if (issue)
        begin
            key_rd_reg <= flow_key_mem[scan_cnt_reg[AW-1:0]];
            seq_rd_reg <= flow_seq_mem[scan_cnt_reg[AW-1:0]];
            rd_idx_reg <= scan_cnt_reg[AW-1:0];
        end
    end

    // Gap between the received and the expected id
    assign seq_ahead = (seq_reg > exp_reg);
    assign gap       = seq_reg - exp_reg;
    assign gap_over  = seq_ahead && (gap > 32'(MAX_REPORTED));

    // Resolve the entry, then count out the missing ids
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            trunc_reg <= 1'b0;
            cnt_reg   <= '0;
        end
        if (cmd.resolve)
        begin
            if (st.hit)
            begin
                widx_reg <= rd_idx_reg;
                new_reg  <= 1'b0;
                exp_reg  <= seq_rd_reg + 32'd1;
            end
            else
            begin
                widx_reg <= fill_reg[AW-1:0];
                new_reg  <= 1'b1;
                exp_reg  <= 32'd1;
            end
        end
        if (cmd.commit)
        begin
            trunc_reg <= gap_over;
            if (gap_over)
            begin
                cnt_reg <= CNT_W'(MAX_REPORTED);
            end
            else if (seq_ahead)
            begin
                cnt_reg <= gap[CNT_W-1:0];
            end
            else
            begin
                cnt_reg <= '0;
            end
        end
        if (cmd.emit_lost)
        begin
            exp_reg <= exp_reg + 32'd1;
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    // Output register: hold a beat until taken
    assign m_tvalid_next = (cmd.emit_lost || cmd.emit_status) ? 1'b1 :
                           (m_tready ? 1'b0 : m_tvalid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_lost)
        begin
            out_reg.pad         <= '0;
            out_reg.truncated   <= 1'b0;
            out_reg.sender_addr <= src_reg;
            out_reg.lost_seq    <= exp_reg;
            out_kind_reg        <= KIND_LOST;
            out_last_reg        <= 1'b0;
        end
        else if (cmd.emit_status)
        begin
            out_reg.pad         <= '0;
            out_reg.truncated   <= trunc_reg;
            out_reg.sender_addr <= src_reg;
            out_reg.lost_seq    <= '0;
            out_kind_reg        <= kind_reg;
            out_last_reg        <= 1'b1;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_DATA_W'(out_reg);
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

endmodule

// File: rtl/flow_sequence_gap_detector_top.sv
// Steps: accept, walk the filled table entries until a hit or a miss, update the entry,
// then one beat per reported lost id, and the status beat that closes the packet.
// Rejected and non-TCP packets go straight to the status beat. A new packet is accepted
// only once the last one's status beat is emitted; the walk uses the single table port.
// Reset (rst_n low, asynchronous) empties the flow table through its fill count
// and drops any pending output beat.
module flow_sequence_gap_detector_top #(
    parameter int unsigned FLOW_ENTRIES = 64,
    parameter int unsigned MAX_REPORTED = 63
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // ip_header_words, ip_protocol, tcp_offset_words, source_addr, dest_addr,
    // source_port, dest_port, packet_seq
    input  logic [fsgd_pkg::S_DATA_W-1:0] s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // lost_seq, sender_addr, truncated, zero pad
    output logic [fsgd_pkg::M_DATA_W-1:0] m_tdata,
    // kind
    output logic [2:0]                    m_tuser,
    output logic                          m_tlast
);
    import fsgd_pkg::*;

    cmd_t    cmd;
    status_t st;

    fsgd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    fsgd_datapath #(
        .FLOW_ENTRIES (FLOW_ENTRIES),
        .MAX_REPORTED (MAX_REPORTED)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .cmd      (cmd),
        .st       (st)
    );

endmodule

// File: rtl/fsgd_checker.sv
module fsgd_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [fsgd_pkg::M_DATA_W-1:0] m_tdata,
    input logic [2:0]                    m_tuser,
    input logic                          m_tlast
);
    import fsgd_pkg::*;

    // A stalled output beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("output beat changed while stalled");

    // Lost-id beats never close a packet and never carry truncation
    a_lost_beat: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == KIND_LOST) |-> !m_tlast && !m_tdata[64])
        else $error("lost-id beat with last or truncated set");

    // Status beats close the packet with a zero lost id
    a_status_beat: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> (m_tuser != KIND_LOST) && (m_tdata[31:0] == 32'd0))
        else $error("status beat malformed");

    // One packet in flight: no accept right after an accept
    a_one_packet: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while a packet is in flight");

endmodule

bind flow_sequence_gap_detector_top fsgd_checker u_fsgd_checker (.*);
